[sv/asgr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// asgr_pkg: shared types, codes and functions of the SGR attribute decoder
// Holds the parser phases, the attribute state, the color palette and the
// functions that apply one SGR code or close a sequence.
// ----------------------------------------------------------------------------
package asgr_pkg;

    typedef enum logic [1:0] {
        PH_TEXT  = 2'd0,
        PH_ESC   = 2'd1,
        PH_PARAM = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        EXT_NONE  = 3'd0,
        EXT_MODE  = 3'd1,
        EXT_INDEX = 3'd2,
        EXT_RED   = 3'd3,
        EXT_GREEN = 3'd4,
        EXT_BLUE  = 3'd5
    } ext_t;

    typedef struct packed {
        ext_t        ext;
        logic        tbg;
        logic [15:0] h0;
        logic [15:0] h1;
        logic [2:0]  flags;
        logic [24:0] fg;
        logic [24:0] bg;
    } sgr_state_t;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_M        = 8'h6D;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [15:0] SGR_RESET          = 16'd0;
    localparam logic [15:0] SGR_BOLD           = 16'd1;
    localparam logic [15:0] SGR_ITALIC         = 16'd3;
    localparam logic [15:0] SGR_UNDERLINE      = 16'd4;
    localparam logic [15:0] SGR_NO_BOLD        = 16'd22;
    localparam logic [15:0] SGR_NO_ITALIC      = 16'd23;
    localparam logic [15:0] SGR_NO_UNDERLINE   = 16'd24;
    localparam logic [15:0] SGR_FG_FIRST       = 16'd30;
    localparam logic [15:0] SGR_FG_LAST        = 16'd37;
    localparam logic [15:0] SGR_FG_EXT         = 16'd38;
    localparam logic [15:0] SGR_FG_DEFAULT     = 16'd39;
    localparam logic [15:0] SGR_BG_FIRST       = 16'd40;
    localparam logic [15:0] SGR_BG_LAST        = 16'd47;
    localparam logic [15:0] SGR_BG_EXT         = 16'd48;
    localparam logic [15:0] SGR_BG_DEFAULT     = 16'd49;
    localparam logic [15:0] SGR_FG_BRIGHT      = 16'd90;
    localparam logic [15:0] SGR_FG_BRIGHT_LAST = 16'd97;
    localparam logic [15:0] SGR_BG_BRIGHT      = 16'd100;
    localparam logic [15:0] SGR_BG_BRIGHT_LAST = 16'd107;
    localparam logic [15:0] SGR_MODE_256       = 16'd5;
    localparam logic [15:0] SGR_MODE_RGB       = 16'd2;
    localparam logic [15:0] CODE_MAX_BYTE      = 16'd255;
    localparam logic [15:0] CUBE_FIRST         = 16'd16;
    localparam logic [15:0] GREY_FIRST         = 16'd232;
    localparam logic [15:0] INDEX_LIMIT        = 16'd256;

    localparam logic [2:0] FLAG_BOLD      = 3'b001;
    localparam logic [2:0] FLAG_ITALIC    = 3'b010;
    localparam logic [2:0] FLAG_UNDERLINE = 3'b100;

    localparam logic [24:0] COLOR_NONE = 25'd0;

    function automatic logic [23:0] palette(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'h1e1e2e;
            4'd1:    c = 24'hf38ba8;
            4'd2:    c = 24'ha6e3a1;
            4'd3:    c = 24'hf9e2af;
            4'd4:    c = 24'h89b4fa;
            4'd5:    c = 24'hcba6f7;
            4'd6:    c = 24'h94e2d5;
            4'd7:    c = 24'hbac2de;
            4'd8:    c = 24'h45475a;
            4'd9:    c = 24'heba0ac;
            4'd10:   c = 24'ha6e3a1;
            4'd11:   c = 24'hf9e2af;
            4'd12:   c = 24'h89dceb;
            4'd13:   c = 24'hf5c2e7;
            4'd14:   c = 24'h94e2d5;
            default: c = 24'hf5e0dc;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] cube_level(input logic [2:0] v);
        logic [7:0] lv;
        lv = (v == 3'd0) ? 8'd0 : 8'd55 + 8'd40 * {5'd0, v};
        return lv;
    endfunction

    // Division by 36 and by 6 is done with reciprocal multiplies that are
    // exact over the cube range of 0 to 215.
    function automatic logic [24:0] colour256(input logic [15:0] idx);
        logic [7:0]  base;
        logic [17:0] pq;
        logic [7:0]  q;
        logic [11:0] pr;
        logic [2:0]  r;
        logic [2:0]  g;
        logic [2:0]  bl;
        logic [7:0]  gi;
        logic [7:0]  grey;
        logic [24:0] c;
        base = idx[7:0] - CUBE_FIRST[7:0];
        pq   = 18'(base) * 18'd171;
        q    = pq[17:10];
        pr   = 12'(q) * 12'd43;
        r    = pr[10:8];
        g    = 3'(q - 8'(r) * 8'd6);
        bl   = 3'(base - q * 8'd6);
        gi   = idx[7:0] - GREY_FIRST[7:0];
        grey = 8'd8 + gi * 8'd10;
        if (idx < CUBE_FIRST) begin
            c = {1'b1, palette(idx[3:0])};
        end else if (idx < GREY_FIRST) begin
            c = {1'b1, cube_level(r), cube_level(g), cube_level(bl)};
        end else if (idx < INDEX_LIMIT) begin
            c = {1'b1, grey, grey, grey};
        end else begin
            c = COLOR_NONE;
        end
        return c;
    endfunction

    function automatic sgr_state_t set_target(input sgr_state_t s, input logic [24:0] c);
        sgr_state_t t;
        t = s;
        if (s.tbg) begin
            t.bg = c;
        end else begin
            t.fg = c;
        end
        return t;
    endfunction

    function automatic sgr_state_t plain_code(input sgr_state_t s, input logic [15:0] v);
        sgr_state_t t;
        logic [15:0] fg_off;
        logic [15:0] fgb_off;
        logic [15:0] bg_off;
        logic [15:0] bgb_off;
        t       = s;
        fg_off  = v - SGR_FG_FIRST;
        fgb_off = v - (SGR_FG_BRIGHT - 16'd8);
        bg_off  = v - SGR_BG_FIRST;
        bgb_off = v - (SGR_BG_BRIGHT - 16'd8);
        case (v) inside
            SGR_RESET: begin
                t.flags = 3'b000;
                t.fg    = COLOR_NONE;
                t.bg    = COLOR_NONE;
            end
            SGR_BOLD:         t.flags = s.flags | FLAG_BOLD;
            SGR_ITALIC:       t.flags = s.flags | FLAG_ITALIC;
            SGR_UNDERLINE:    t.flags = s.flags | FLAG_UNDERLINE;
            SGR_NO_BOLD:      t.flags = s.flags & ~FLAG_BOLD;
            SGR_NO_ITALIC:    t.flags = s.flags & ~FLAG_ITALIC;
            SGR_NO_UNDERLINE: t.flags = s.flags & ~FLAG_UNDERLINE;
            [SGR_FG_FIRST:SGR_FG_LAST]:        t.fg = {1'b1, palette(fg_off[3:0])};
            [SGR_FG_BRIGHT:SGR_FG_BRIGHT_LAST]: t.fg = {1'b1, palette(fgb_off[3:0])};
            SGR_FG_DEFAULT:   t.fg = COLOR_NONE;
            [SGR_BG_FIRST:SGR_BG_LAST]:        t.bg = {1'b1, palette(bg_off[3:0])};
            [SGR_BG_BRIGHT:SGR_BG_BRIGHT_LAST]: t.bg = {1'b1, palette(bgb_off[3:0])};
            SGR_BG_DEFAULT:   t.bg = COLOR_NONE;
            default:          t = s;
        endcase
        return t;
    endfunction

    // Applies one code when no extended color is pending or only its mode
    // is awaited.
    function automatic sgr_state_t feed_low(input sgr_state_t s, input logic [15:0] v);
        sgr_state_t t;
        t = s;
        if (s.ext == EXT_MODE) begin
            if (v == SGR_MODE_256) begin
                t.ext = EXT_INDEX;
            end else if (v == SGR_MODE_RGB) begin
                t.ext = EXT_RED;
            end else begin
                t     = set_target(s, COLOR_NONE);
                t.ext = EXT_NONE;
            end
        end else begin
            t.ext = EXT_NONE;
            if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
                t.tbg = (v == SGR_BG_EXT);
                t.ext = EXT_MODE;
            end else begin
                t = plain_code(t, v);
            end
        end
        return t;
    endfunction

    function automatic sgr_state_t feed_code(input sgr_state_t s, input logic [15:0] v);
        sgr_state_t t;
        t = s;
        unique case (s.ext)
            EXT_INDEX: begin
                t     = set_target(s, colour256(v));
                t.ext = EXT_NONE;
            end
            EXT_RED: begin
                t.h0  = v;
                t.ext = EXT_GREEN;
            end
            EXT_GREEN: begin
                t.h1  = v;
                t.ext = EXT_BLUE;
            end
            EXT_BLUE: begin
                if (s.h0 <= CODE_MAX_BYTE && s.h1 <= CODE_MAX_BYTE && v <= CODE_MAX_BYTE) begin
                    t = set_target(s, {1'b1, s.h0[7:0], s.h1[7:0], v[7:0]});
                end else begin
                    t = set_target(s, COLOR_NONE);
                end
                t.ext = EXT_NONE;
            end
            default: t = feed_low(s, v);
        endcase
        return t;
    endfunction

    // Closes a sequence: an extended color cut short is cleared and any held
    // components are replayed as ordinary codes.
    function automatic sgr_state_t finish(input sgr_state_t s);
        sgr_state_t t;
        ext_t        e;
        t     = s;
        e     = s.ext;
        t.ext = EXT_NONE;
        if (e == EXT_INDEX || e == EXT_RED || e == EXT_GREEN || e == EXT_BLUE) begin
            t = set_target(t, COLOR_NONE);
        end
        if (e == EXT_GREEN || e == EXT_BLUE) begin
            t = feed_low(t, s.h0);
        end
        if (e == EXT_BLUE) begin
            t = feed_low(t, s.h1);
        end
        if (t.ext == EXT_INDEX || t.ext == EXT_RED) begin
            t = set_target(t, COLOR_NONE);
        end
        t.ext = EXT_NONE;
        return t;
    endfunction

endpackage
`default_nettype wire

[sv/ansi_sgr_attribute_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_decoder: terminal byte stream to attributed characters
// Parses SGR escape sequences and tags every displayed byte with the
// attributes and colors in force.
// ----------------------------------------------------------------------------
// A byte is taken in every clock cycle as long as results leave at the same
// pace. Each input beat yields up to five result beats, one per cycle while
// m_ready is high: a tab gives four spaces, and an escape not followed by
// '[' is sent as text ahead of the next byte. Bytes of an escape sequence
// yield no result. The input stalls only while the output register still
// has results of the previous byte to send, so a tab holds it until its
// spaces are sent. The last result beat of each input byte carries m_run_last.
module ansi_sgr_attribute_decoder
    import asgr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_text_byte,
    output logic             m_is_bold,
    output logic             m_is_italic,
    output logic             m_is_underline,
    output logic             m_fg_valid,
    output logic [23:0]      m_fg_rgb,
    output logic             m_bg_valid,
    output logic [23:0]      m_bg_rgb,
    output logic             m_run_last
);

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic        malf_reg, malf_next;
    sgr_state_t  st_reg, st_next;

    logic        valid_reg;
    logic [7:0]  text_reg;
    logic [7:0]  rest_reg;
    logic [2:0]  rem_reg;
    logic        last_reg;
    logic [2:0]  flags_reg;
    logic [24:0] fg_reg;
    logic [24:0] bg_reg;

    logic        s_fire;
    logic        m_fire;
    logic        prefix;
    logic [2:0]  body_n;
    logic [7:0]  body_byte;
    logic [2:0]  total;
    logic [19:0] acc_x10;
    logic [15:0] code;

    assign s_ready = (rem_reg == 3'd0) && (!valid_reg || m_ready);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = valid_reg && m_ready;

    assign acc_x10 = 20'({acc_reg, 3'b000}) + 20'({acc_reg, 1'b0})
                   + 20'(s_in_byte - CH_ZERO);
    assign code    = malf_reg ? SGR_RESET : acc_reg;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        malf_next  = malf_reg;
        st_next    = st_reg;
        unique case (phase_reg)
            PH_PARAM: begin
                if (s_in_byte >= CH_ZERO && s_in_byte <= CH_NINE) begin
                    acc_next = (acc_x10 > 20'hFFFF) ? 16'hFFFF : acc_x10[15:0];
                end else if (s_in_byte == CH_SEMI || s_in_byte == CH_M) begin
                    st_next   = feed_code(st_reg, code);
                    acc_next  = 16'd0;
                    malf_next = 1'b0;
                    if (s_in_byte == CH_M) begin
                        st_next    = finish(st_next);
                        phase_next = PH_TEXT;
                    end
                end else begin
                    malf_next = 1'b1;
                end
            end
            PH_ESC: begin
                if (s_in_byte == CH_LBRACKET) begin
                    phase_next  = PH_PARAM;
                    acc_next    = 16'd0;
                    malf_next   = 1'b0;
                    st_next.ext = EXT_NONE;
                end else if (s_in_byte == CH_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    phase_next = PH_TEXT;
                end
            end
            default: begin
                phase_next = (s_in_byte == CH_ESC) ? PH_ESC : PH_TEXT;
            end
        endcase
    end

    always_comb begin
        prefix    = 1'b0;
        body_n    = 3'd0;
        body_byte = s_in_byte;
        if (phase_reg != PH_PARAM &&
            !(phase_reg == PH_ESC && s_in_byte == CH_LBRACKET)) begin
            prefix = (phase_reg == PH_ESC);
            if (s_in_byte == CH_TAB) begin
                body_n    = 3'd4;
                body_byte = CH_SPACE;
            end else if (s_in_byte != CH_ESC) begin
                body_n = 3'd1;
            end
        end
        total = body_n + {2'b00, prefix};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            acc_reg   <= 16'd0;
            malf_reg  <= 1'b0;
            st_reg    <= '{ext: EXT_NONE, tbg: 1'b0, h0: 16'd0, h1: 16'd0,
                           flags: 3'b000, fg: COLOR_NONE, bg: COLOR_NONE};
            valid_reg <= 1'b0;
            rem_reg   <= 3'd0;
        end else begin
            if (s_fire) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                malf_reg  <= malf_next;
                st_reg    <= st_next;
            end
            if (s_fire && total != 3'd0) begin
                valid_reg <= 1'b1;
                rem_reg   <= total - 3'd1;
            end else if (m_fire) begin
                if (rem_reg != 3'd0) begin
                    rem_reg <= rem_reg - 3'd1;
                end else begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && total != 3'd0) begin
            text_reg  <= prefix ? CH_ESC : body_byte;
            rest_reg  <= body_byte;
            last_reg  <= (total == 3'd1);
            flags_reg <= st_reg.flags;
            fg_reg    <= st_reg.fg;
            bg_reg    <= st_reg.bg;
        end else if (m_fire && rem_reg != 3'd0) begin
            text_reg <= rest_reg;
            last_reg <= (rem_reg == 3'd1);
        end
    end

    assign m_valid        = valid_reg;
    assign m_text_byte    = text_reg;
    assign m_is_bold      = flags_reg[0];
    assign m_is_italic    = flags_reg[1];
    assign m_is_underline = flags_reg[2];
    assign m_fg_valid     = fg_reg[24];
    assign m_fg_rgb       = fg_reg[23:0];
    assign m_bg_valid     = bg_reg[24];
    assign m_bg_rgb       = bg_reg[23:0];
    assign m_run_last     = last_reg;

endmodule
`default_nettype wire

[tb/tb_ansi_sgr_attribute_decoder.sv]
// ----------------------------------------------------------------------------
// tb_ansi_sgr_attribute_decoder: self-checking bench for the SGR decoder
// Feeds terminal byte streams (plain text, tabs, well-formed and broken SGR
// escape sequences, lone escapes) and compares every result beat against an
// independent model of the attribute state, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_ansi_sgr_attribute_decoder;
    import asgr_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 310;
    localparam int QUIET_AFTER = 250;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0]  text;
        logic        bold;
        logic        italic;
        logic        underline;
        logic        fg_valid;
        logic [23:0] fg_rgb;
        logic        bg_valid;
        logic [23:0] bg_rgb;
        logic        run_last;
    } glyph_t;

    class sgr_glyph_board;
        phase_t      phase;
        logic [15:0] acc;
        logic        bad_digit;
        ext_t        ext;
        logic        to_bg;
        logic [15:0] held [2];
        logic [2:0]  flags;
        logic [24:0] fg;
        logic [24:0] bg;
        logic [23:0] ansi16 [16];
        glyph_t      glyph_q [$];
        int          mismatches;

        function new();
            phase      = PH_TEXT;
            acc        = '0;
            bad_digit  = 1'b0;
            ext        = EXT_NONE;
            to_bg      = 1'b0;
            held[0]    = '0;
            held[1]    = '0;
            flags      = '0;
            fg         = COLOR_NONE;
            bg         = COLOR_NONE;
            mismatches = 0;
            ansi16 = '{24'h1e1e2e, 24'hf38ba8, 24'ha6e3a1, 24'hf9e2af,
                       24'h89b4fa, 24'hcba6f7, 24'h94e2d5, 24'hbac2de,
                       24'h45475a, 24'heba0ac, 24'ha6e3a1, 24'hf9e2af,
                       24'h89dceb, 24'hf5c2e7, 24'h94e2d5, 24'hf5e0dc};
        endfunction

        function logic [7:0] ramp(int v);
            return (v == 0) ? 8'd0 : 8'(55 + 40 * v);
        endfunction

        function logic [24:0] indexed_color(logic [15:0] n);
            int k;
            if (n < CUBE_FIRST) begin
                return {1'b1, ansi16[n[3:0]]};
            end
            if (n < GREY_FIRST) begin
                k = int'(n) - int'(CUBE_FIRST);
                return {1'b1, ramp(k / 36), ramp((k / 6) % 6), ramp(k % 6)};
            end
            if (n < INDEX_LIMIT) begin
                k = 8 + (int'(n) - int'(GREY_FIRST)) * 10;
                return {1'b1, 8'(k), 8'(k), 8'(k)};
            end
            return COLOR_NONE;
        endfunction

        function void paint(logic [24:0] c);
            if (to_bg) begin
                bg = c;
            end else begin
                fg = c;
            end
        endfunction

        function void simple_code(logic [15:0] v);
            if (v == SGR_RESET) begin
                flags = '0;
                fg    = COLOR_NONE;
                bg    = COLOR_NONE;
            end else if (v == SGR_BOLD) begin
                flags |= FLAG_BOLD;
            end else if (v == SGR_ITALIC) begin
                flags |= FLAG_ITALIC;
            end else if (v == SGR_UNDERLINE) begin
                flags |= FLAG_UNDERLINE;
            end else if (v == SGR_NO_BOLD) begin
                flags &= ~FLAG_BOLD;
            end else if (v == SGR_NO_ITALIC) begin
                flags &= ~FLAG_ITALIC;
            end else if (v == SGR_NO_UNDERLINE) begin
                flags &= ~FLAG_UNDERLINE;
            end else if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST) begin
                fg = {1'b1, ansi16[4'(v - SGR_FG_FIRST)]};
            end else if (v >= SGR_FG_BRIGHT && v <= SGR_FG_BRIGHT_LAST) begin
                fg = {1'b1, ansi16[4'(v - SGR_FG_BRIGHT + 16'd8)]};
            end else if (v == SGR_FG_DEFAULT) begin
                fg = COLOR_NONE;
            end else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST) begin
                bg = {1'b1, ansi16[4'(v - SGR_BG_FIRST)]};
            end else if (v >= SGR_BG_BRIGHT && v <= SGR_BG_BRIGHT_LAST) begin
                bg = {1'b1, ansi16[4'(v - SGR_BG_BRIGHT + 16'd8)]};
            end else if (v == SGR_BG_DEFAULT) begin
                bg = COLOR_NONE;
            end
        endfunction

        function void apply_code(logic [15:0] v);
            case (ext)
                EXT_MODE: begin
                    if (v == SGR_MODE_256) begin
                        ext = EXT_INDEX;
                    end else if (v == SGR_MODE_RGB) begin
                        ext = EXT_RED;
                    end else begin
                        paint(COLOR_NONE);
                        ext = EXT_NONE;
                    end
                end
                EXT_INDEX: begin
                    paint(indexed_color(v));
                    ext = EXT_NONE;
                end
                EXT_RED: begin
                    held[0] = v;
                    ext     = EXT_GREEN;
                end
                EXT_GREEN: begin
                    held[1] = v;
                    ext     = EXT_BLUE;
                end
                EXT_BLUE: begin
                    if (held[0] <= CODE_MAX_BYTE && held[1] <= CODE_MAX_BYTE &&
                        v <= CODE_MAX_BYTE) begin
                        paint({1'b1, held[0][7:0], held[1][7:0], v[7:0]});
                    end else begin
                        paint(COLOR_NONE);
                    end
                    ext = EXT_NONE;
                end
                default: begin
                    ext = EXT_NONE;
                    if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
                        to_bg = (v == SGR_BG_EXT);
                        ext   = EXT_MODE;
                    end else begin
                        simple_code(v);
                    end
                end
            endcase
        endfunction

        // An extension cut short by the final byte clears its color, and any
        // held components are replayed as ordinary codes, which may in turn
        // leave another extension open.
        function void close_seq();
            for (int pass = 0; pass < 3; pass++) begin
                ext_t        e;
                logic [15:0] h0;
                logic [15:0] h1;
                e   = ext;
                h0  = held[0];
                h1  = held[1];
                ext = EXT_NONE;
                if (e == EXT_INDEX || e == EXT_RED) begin
                    paint(COLOR_NONE);
                end else if (e == EXT_GREEN) begin
                    paint(COLOR_NONE);
                    apply_code(h0);
                end else if (e == EXT_BLUE) begin
                    paint(COLOR_NONE);
                    apply_code(h0);
                    apply_code(h1);
                end else begin
                    break;
                end
            end
            ext = EXT_NONE;
        endfunction

        function void push(logic [7:0] ch);
            glyph_t g;
            g.text      = ch;
            g.bold      = |(flags & FLAG_BOLD);
            g.italic    = |(flags & FLAG_ITALIC);
            g.underline = |(flags & FLAG_UNDERLINE);
            g.fg_valid  = fg[24];
            g.fg_rgb    = fg[23:0];
            g.bg_valid  = bg[24];
            g.bg_rgb    = bg[23:0];
            g.run_last  = 1'b0;
            glyph_q.push_back(g);
        endfunction

        function void take_byte(logic [7:0] b);
            int n0;
            int t;
            n0 = glyph_q.size();
            if (phase == PH_PARAM) begin
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    t   = int'(acc) * 10 + int'(b) - int'(CH_ZERO);
                    acc = (t > 65535) ? 16'hFFFF : 16'(t);
                end else if (b == CH_SEMI || b == CH_M) begin
                    apply_code(bad_digit ? 16'd0 : acc);
                    acc       = '0;
                    bad_digit = 1'b0;
                    if (b == CH_M) begin
                        close_seq();
                        phase = PH_TEXT;
                    end
                end else begin
                    bad_digit = 1'b1;
                end
                return;
            end
            if (phase == PH_ESC) begin
                if (b == CH_LBRACKET) begin
                    phase     = PH_PARAM;
                    acc       = '0;
                    bad_digit = 1'b0;
                    ext       = EXT_NONE;
                    return;
                end
                push(CH_ESC);
            end
            phase = PH_TEXT;
            if (b == CH_ESC) begin
                phase = PH_ESC;
            end else if (b == CH_TAB) begin
                repeat (4) push(CH_SPACE);
            end else begin
                push(b);
            end
            if (glyph_q.size() > n0) begin
                glyph_q[$].run_last = 1'b1;
            end
        endfunction

        function void match_glyph(glyph_t got);
            glyph_t want;
            string  diff;
            if (glyph_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: byte %h", got.text);
                end
                return;
            end
            want = glyph_q.pop_front();
            diff = "";
            if (got.text != want.text) diff = {diff, " text_byte"};
            if (got.bold != want.bold) diff = {diff, " is_bold"};
            if (got.italic != want.italic) diff = {diff, " is_italic"};
            if (got.underline != want.underline) diff = {diff, " is_underline"};
            if (got.fg_valid != want.fg_valid) diff = {diff, " fg_valid"};
            if (got.fg_rgb != want.fg_rgb) diff = {diff, " fg_rgb"};
            if (got.bg_valid != want.bg_valid) diff = {diff, " bg_valid"};
            if (got.bg_rgb != want.bg_rgb) diff = {diff, " bg_rgb"};
            if (got.run_last != want.run_last) diff = {diff, " run_last"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch in%s: expected %h b%b i%b u%b fg %b/%h bg %b/%h l%b",
                             diff, want.text, want.bold, want.italic, want.underline,
                             want.fg_valid, want.fg_rgb, want.bg_valid, want.bg_rgb,
                             want.run_last);
                    $display("    got %h b%b i%b u%b fg %b/%h bg %b/%h l%b",
                             got.text, got.bold, got.italic, got.underline,
                             got.fg_valid, got.fg_rgb, got.bg_valid, got.bg_rgb,
                             got.run_last);
                end
            end
        endfunction

        function int pending();
            return glyph_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_text_byte;
    logic        m_is_bold;
    logic        m_is_italic;
    logic        m_is_underline;
    logic        m_fg_valid;
    logic [23:0] m_fg_rgb;
    logic        m_bg_valid;
    logic [23:0] m_bg_rgb;
    logic        m_run_last;

    logic        idle_on   = 1'b1;
    logic        hold_off  = 1'b0;
    int          sent      = 0;
    int          rx_gap    = 0;
    int          cycles    = 0;
    logic [7:0]  seq_q [$];
    sgr_glyph_board sb = new();

    ansi_sgr_attribute_decoder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_text_byte    (m_text_byte),
        .m_is_bold      (m_is_bold),
        .m_is_italic    (m_is_italic),
        .m_is_underline (m_is_underline),
        .m_fg_valid     (m_fg_valid),
        .m_fg_rgb       (m_fg_rgb),
        .m_bg_valid     (m_bg_valid),
        .m_bg_rgb       (m_bg_rgb),
        .m_run_last     (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_ansi_sgr_attribute_decoder: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin : result_side
        glyph_t got;
        if (aresetn && m_valid && m_ready) begin
            got = {m_text_byte, m_is_bold, m_is_italic, m_is_underline, m_fg_valid,
                   m_fg_rgb, m_bg_valid, m_bg_rgb, m_run_last};
            sb.match_glyph(got);
        end
        if (rx_gap != 0) begin
            rx_gap--;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(1, 17);
        end
        m_ready <= aresetn && rx_gap == 0 && !hold_off;
    end

    // The result side stops accepting for a long stretch while bytes keep
    // coming, so the decoder has to back up into its input.
    initial begin
        wait (sent >= HOLD_AT);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.take_byte(b);
        sent++;
    endtask

    function automatic void put_num(int v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) begin
            seq_q.push_back(s[i]);
        end
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(0, 255));
        end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_M);
        return b;
    endfunction

    function automatic int pick_plain();
        int pick [7] = '{SGR_RESET, SGR_BOLD, SGR_ITALIC, SGR_UNDERLINE,
                         SGR_NO_BOLD, SGR_NO_ITALIC, SGR_NO_UNDERLINE};
        case ($urandom_range(0, 7))
            0: return SGR_FG_FIRST + $urandom_range(0, 9);
            1: return SGR_BG_FIRST + $urandom_range(0, 9);
            2: return SGR_FG_BRIGHT + $urandom_range(0, 7);
            3: return SGR_BG_BRIGHT + $urandom_range(0, 7);
            4: return $urandom_range(0, 120);
            default: return pick[$urandom_range(0, 6)];
        endcase
    endfunction

    function automatic int pick_component();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(256, 70000);
        end
        return $urandom_range(0, 255);
    endfunction

    function automatic int pick_replay();
        case ($urandom_range(0, 5))
            0: return SGR_BOLD;
            1: return SGR_FG_EXT;
            2: return SGR_BG_EXT;
            3: return SGR_MODE_256;
            4: return SGR_MODE_RGB;
            default: return $urandom_range(0, 110);
        endcase
    endfunction

    function automatic void build_sgr();
        int ncodes;
        int tgt;
        ncodes = $urandom_range(0, 4);
        seq_q.push_back(CH_ESC);
        seq_q.push_back(CH_LBRACKET);
        for (int i = 0; i < ncodes; i++) begin
            if (i != 0) seq_q.push_back(CH_SEMI);
            tgt = $urandom_range(0, 1) ? SGR_BG_EXT : SGR_FG_EXT;
            case ($urandom_range(0, 11))
                4, 5: begin
                    put_num(tgt);
                    seq_q.push_back(CH_SEMI);
                    put_num(SGR_MODE_256);
                    seq_q.push_back(CH_SEMI);
                    put_num($urandom_range(0, 300));
                end
                6, 7: begin
                    put_num(tgt);
                    seq_q.push_back(CH_SEMI);
                    put_num(SGR_MODE_RGB);
                    repeat (3) begin
                        seq_q.push_back(CH_SEMI);
                        put_num(pick_component());
                    end
                end
                8: begin
                    put_num(tgt);
                    seq_q.push_back(CH_SEMI);
                    put_num($urandom_range(0, 9));
                end
                9: ;
                10: begin
                    put_num($urandom_range(0, 120));
                    seq_q.push_back(junk_byte());
                    if ($urandom_range(0, 1)) put_num($urandom_range(0, 50));
                end
                11: repeat ($urandom_range(5, 9)) seq_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                default: put_num(pick_plain());
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            if (ncodes != 0) seq_q.push_back(CH_SEMI);
            put_num($urandom_range(0, 1) ? SGR_BG_EXT : SGR_FG_EXT);
            seq_q.push_back(CH_SEMI);
            if ($urandom_range(0, 3) == 0) begin
                put_num(SGR_MODE_256);
            end else begin
                put_num(SGR_MODE_RGB);
                repeat ($urandom_range(0, 2)) begin
                    seq_q.push_back(CH_SEMI);
                    put_num(pick_replay());
                end
            end
        end
        seq_q.push_back(CH_M);
    endfunction

    function automatic void build_noise();
        logic [7:0] b;
        seq_q.push_back(CH_ESC);
        if ($urandom_range(0, 1)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_LBRACKET);
            seq_q.push_back(b);
        end else begin
            seq_q.push_back(CH_LBRACKET);
            repeat ($urandom_range(1, 5)) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_M);
                seq_q.push_back(b);
            end
            seq_q.push_back(CH_M);
        end
    endfunction

    function automatic void build_text();
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 7))
                0: seq_q.push_back(CH_TAB);
                1: seq_q.push_back(8'($urandom_range(0, 255)));
                default: seq_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
            endcase
        end
    endfunction

    initial begin : stimulus
        logic [7:0] opening [24] = '{8'h00, 8'hFF, CH_TAB, CH_ESC, "A", CH_ESC, CH_TAB,
                                     CH_ESC, CH_LBRACKET, "1", CH_SEMI, "3", "8", CH_SEMI,
                                     "2", CH_SEMI, "7", CH_M, "x", CH_ESC, CH_ESC,
                                     CH_LBRACKET, CH_M, "y"};
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (opening[i]) send_byte(opening[i]);
        while (sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                build_text();
            end else if (pick < 9) begin
                build_sgr();
            end else begin
                build_noise();
            end
            while (seq_q.size() != 0) send_byte(seq_q.pop_front());
            if (sent >= QUIET_AFTER) idle_on <= 1'b0;
        end
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("tb_ansi_sgr_attribute_decoder: done, clean");
        end else begin
            $display("tb_ansi_sgr_attribute_decoder: done, errors");
        end
        $finish;
    end

endmodule

[ansi_sgr_attribute_decoder.f]
sv/asgr_pkg.sv
sv/ansi_sgr_attribute_decoder.sv
tb/tb_ansi_sgr_attribute_decoder.sv
